FILE: hdl/fts_pkg.sv
package fts_pkg;

   localparam int DEF_MAX_THREADS = 16;

   localparam int CMD_W    = 3;
   localparam int NOW_W    = 64;
   localparam int AMOUNT_W = 32;
   localparam int TGT_W    = 4;
   localparam int SLOTF_W  = 4;
   localparam int ID_W     = 32;
   localparam int WOKEN_W  = 5;
   localparam int STATUS_W = 2;
   localparam int RATE_W   = 20;

   localparam int PROD_W   = AMOUNT_W + RATE_W;
   localparam int MS_PER_S = 1000;
   localparam int REM_W    = $clog2(MS_PER_S);
   localparam int CNT_W    = $clog2(PROD_W + 1);

   // divide by 1000 in 13-bit digits, each digit through a reciprocal multiply
   localparam int DIG_W     = 13;
   localparam int DIV_STEPS = PROD_W / DIG_W;
   localparam int V_W       = REM_W + DIG_W;
   localparam int RCP_SH    = 33;
   localparam int RCP_W     = 24;
   // 2^33 / 1000 rounded up, exact for partial dividends below 2^23
   localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'(8589935);

   localparam logic [RATE_W-1:0] TICK_RATE_RESET = RATE_W'(1000);

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE   = 3'd0,
      CMD_SCHED    = 3'd1,
      CMD_SLEEP_MS = 3'd2,
      CMD_SLEEP_S  = 3'd3,
      CMD_KILL     = 3'd4,
      CMD_EXIT     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_BAD_SLOT = 2'd2,
      STAT_NOOP     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SS_FREE    = 2'd0,
      SS_READY   = 2'd1,
      SS_RUNNING = 2'd2,
      SS_SLEEP   = 2'd3
   } slot_state_type;

   typedef struct packed {
      logic                start;
      logic                is_ms;
      logic [AMOUNT_W-1:0] amount;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] delay;
   } div_rsp_type;

endpackage

FILE: hdl/fts_ifs.sv
interface fts_req_if;
   import fts_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [NOW_W-1:0]    now_ticks;
   logic [AMOUNT_W-1:0] amount;
   logic [TGT_W-1:0]    target_slot;

   modport source (output valid, output cmd, output now_ticks, output amount,
                   output target_slot, input ready);
   modport sink (input valid, input cmd, input now_ticks, input amount,
                 input target_slot, output ready);
endinterface

interface fts_rsp_if;
   import fts_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOTF_W-1:0]  running_slot;
   logic                switched;
   logic [SLOTF_W-1:0]  new_slot;
   logic [ID_W-1:0]     new_id;
   logic [WOKEN_W-1:0]  woken_count;

   modport source (output valid, output status, output running_slot, output switched,
                   output new_slot, output new_id, output woken_count, input ready);
   modport sink (input valid, input status, input running_slot, input switched,
                 input new_slot, input new_id, input woken_count, output ready);
endinterface

interface fts_csr_if;
   import fts_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/fts_div.sv
module fts_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [fts_pkg::RATE_W-1:0] rate,
   input  fts_pkg::div_req_type       dreq,
   output fts_pkg::div_rsp_type       drsp
);
   import fts_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV} dstate_type;

   dstate_type             state_ff;
   logic [AMOUNT_W-1:0]    amt_ff;
   logic                   ms_ff;
   logic [PROD_W-1:0]      acc_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   done_ff;
   logic                   ph_ff;
   logic [DIG_W-1:0]       qd_ff;
   logic [V_W-1:0]         dv;
   logic [RCP_W+V_W-1:0]   qprod;

   assign dv    = {rem_ff, acc_ff[PROD_W-1 -: DIG_W]};
   assign qprod = (RCP_W+V_W)'(dv) * (RCP_W+V_W)'(RCP_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         amt_ff   <= '0;
         ms_ff    <= 1'b0;
         acc_ff   <= '0;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         ph_ff    <= 1'b0;
         qd_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (dreq.start) begin
                  amt_ff   <= dreq.amount;
                  ms_ff    <= dreq.is_ms;
                  state_ff <= D_MUL;
               end
            end
            D_MUL: begin
               // product of duration and tick rate
               acc_ff <= PROD_W'(amt_ff) * PROD_W'(rate);
               rem_ff <= '0;
               ph_ff  <= 1'b0;
               cnt_ff <= CNT_W'(DIV_STEPS);
               if (ms_ff) begin
                  state_ff <= D_DIV;
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            D_DIV: begin
               // each quotient digit takes two phases: estimate, then remainder
               if (!ph_ff) begin
                  qd_ff <= qprod[RCP_SH +: DIG_W];
                  ph_ff <= 1'b1;
               end else begin
                  rem_ff <= REM_W'(dv - V_W'(qd_ff) * V_W'(MS_PER_S));
                  acc_ff <= {acc_ff[PROD_W-DIG_W-1:0], qd_ff};
                  ph_ff  <= 1'b0;
                  cnt_ff <= cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     done_ff  <= 1'b1;
                     state_ff <= D_IDLE;
                  end
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign drsp.done  = done_ff;
   assign drsp.delay = acc_ff;

endmodule

FILE: hdl/fts_core.sv
module fts_core #(
   parameter int MAX_THREADS = fts_pkg::DEF_MAX_THREADS
) (
   input  logic                 clock,
   input  logic                 reset,
   fts_req_if.sink              req,
   fts_rsp_if.source            rsp,
   output fts_pkg::div_req_type dreq,
   input  fts_pkg::div_rsp_type drsp
);
   import fts_pkg::*;

   localparam int SW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int PW = $clog2(MAX_THREADS + 1);
   localparam logic [PW-1:0] NONE = PW'(MAX_THREADS);
   localparam logic [SW-1:0] LAST = SW'(MAX_THREADS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN, S_SCH0, S_SCH1, S_SWK0, S_SWK1, S_SWK2, S_DSP0, S_DSP1,
      S_SLPCHK, S_SLPDIV, S_KCHK, S_RM0, S_RM1, S_KFREE, S_PSH1, S_PSH2, S_OUT
   } state_type;

   // storage
   slot_state_type    st_mem [MAX_THREADS];
   logic              st_vld_ff [MAX_THREADS];
   logic [PW-1:0]     link_mem [MAX_THREADS];
   logic [NOW_W-1:0]  wake_mem [MAX_THREADS];
   slot_state_type    st_q;
   logic [PW-1:0]     link_q;
   logic [NOW_W-1:0]  wake_q;

   // control state
   state_type           state_ff, state_in, ret_ff, ret_in;
   logic [PW-1:0]       rhead_ff, rhead_in, rtail_ff, rtail_in;
   logic [PW-1:0]       shead_ff, shead_in, stail_ff, stail_in;
   logic [SW-1:0]       cur_ff, cur_in, old_ff, old_in;
   logic [ID_W-1:0]     idc_ff, idc_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [SW-1:0]       tgt_ff, tgt_in, sc_ff, sc_in, ps_ff, ps_in;
   logic                tbad_ff, tbad_in, psl_ff, psl_in, rl_ff, rl_in;
   logic [PW-1:0]       cs_ff, cs_in, prev_ff, prev_in, nxt_ff, nxt_in;
   logic [PW-1:0]       guard_ff, guard_in, woken_ff, woken_in;
   status_type          status_ff, status_in;
   logic [SLOTF_W-1:0]  nslot_ff, nslot_in;
   logic [ID_W-1:0]     nid_ff, nid_in;

   // memory ports
   logic              st_we, lk_we, wk_we;
   logic [SW-1:0]     st_wa, lk_wa, rd_addr;
   slot_state_type    st_wd;
   logic [PW-1:0]     lk_wd;
   logic [NOW_W:0]    wsum;
   logic [NOW_W-1:0]  wt;

   assign wsum = {1'b0, now_ff} + (NOW_W+1)'(drsp.delay);
   assign wt   = wsum[NOW_W] ? {NOW_W{1'b1}} : wsum[NOW_W-1:0];

   always_comb begin
      state_in  = state_ff;  ret_in   = ret_ff;
      rhead_in  = rhead_ff;  rtail_in = rtail_ff;
      shead_in  = shead_ff;  stail_in = stail_ff;
      cur_in    = cur_ff;    old_in   = old_ff;   idc_in = idc_ff;
      cmd_in    = cmd_ff;    now_in   = now_ff;   amt_in = amt_ff;
      tgt_in    = tgt_ff;    sc_in    = sc_ff;    ps_in  = ps_ff;
      tbad_in   = tbad_ff;   psl_in   = psl_ff;   rl_in  = rl_ff;
      cs_in     = cs_ff;     prev_in  = prev_ff;  nxt_in = nxt_ff;
      guard_in  = guard_ff;  woken_in = woken_ff;
      status_in = status_ff; nslot_in = nslot_ff; nid_in = nid_ff;
      st_we = 1'b0; st_wa = cur_ff; st_wd = SS_FREE;
      lk_we = 1'b0; lk_wa = '0;     lk_wd = NONE;
      wk_we = 1'b0;
      rd_addr = '0;
      dreq.start  = 1'b0;
      dreq.is_ms  = (cmd_type'(cmd_ff) == CMD_SLEEP_MS);
      dreq.amount = amt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in    = req.cmd;
               now_in    = req.now_ticks;
               amt_in    = req.amount;
               old_in    = cur_ff;
               woken_in  = '0;
               nslot_in  = '0;
               nid_in    = '0;
               status_in = STAT_OK;
               case (cmd_type'(req.cmd))
                  CMD_CREATE: begin
                     sc_in    = '0;
                     rd_addr  = '0;
                     state_in = S_SCAN;
                  end
                  CMD_SCHED: state_in = S_SCH0;
                  CMD_SLEEP_MS, CMD_SLEEP_S: begin
                     rd_addr  = cur_ff;
                     state_in = S_SLPCHK;
                  end
                  CMD_KILL: begin
                     tgt_in   = SW'(req.target_slot);
                     tbad_in  = (32'(req.target_slot) >= MAX_THREADS);
                     rd_addr  = SW'(req.target_slot);
                     state_in = S_KCHK;
                  end
                  CMD_EXIT: begin
                     tgt_in   = cur_ff;
                     tbad_in  = 1'b0;
                     rd_addr  = cur_ff;
                     state_in = S_KCHK;
                  end
                  default: begin
                     status_in = STAT_NOOP;
                     state_in  = S_OUT;
                  end
               endcase
            end
         end
         // lowest free slot, one slot per cycle
         S_SCAN: begin
            if (st_q == SS_FREE) begin
               st_we    = 1'b1;
               st_wa    = sc_ff;
               st_wd    = SS_READY;
               nslot_in = SLOTF_W'(sc_ff);
               nid_in   = idc_ff;
               idc_in   = idc_ff + ID_W'(1);
               ps_in    = sc_ff;
               psl_in   = 1'b0;
               ret_in   = S_OUT;
               state_in = S_PSH1;
            end else if (sc_ff == LAST) begin
               status_in = STAT_FULL;
               state_in  = S_OUT;
            end else begin
               sc_in   = sc_ff + SW'(1);
               rd_addr = sc_ff + SW'(1);
            end
         end
         S_SCH0: begin
            rd_addr  = cur_ff;
            cs_in    = shead_ff;
            prev_in  = NONE;
            guard_in = '0;
            state_in = S_SCH1;
         end
         S_SCH1: begin
            if (st_q == SS_RUNNING) begin
               st_we    = 1'b1;
               st_wa    = cur_ff;
               st_wd    = SS_READY;
               ps_in    = cur_ff;
               psl_in   = 1'b0;
               ret_in   = S_SWK0;
               state_in = S_PSH1;
            end else begin
               state_in = S_SWK0;
            end
         end
         // sleep list walk
         S_SWK0: begin
            if (cs_ff == NONE || guard_ff == PW'(MAX_THREADS)) begin
               state_in = S_DSP0;
            end else begin
               rd_addr  = SW'(cs_ff);
               state_in = S_SWK1;
            end
         end
         S_SWK1: begin
            nxt_in = link_q;
            if (now_ff >= wake_q) begin
               if (prev_ff == NONE) begin
                  shead_in = link_q;
               end else begin
                  lk_we = 1'b1;
                  lk_wa = SW'(prev_ff);
                  lk_wd = link_q;
               end
               if (stail_ff == cs_ff) begin
                  stail_in = prev_ff;
               end
               st_we    = 1'b1;
               st_wa    = SW'(cs_ff);
               st_wd    = SS_READY;
               woken_in = woken_ff + PW'(1);
               ps_in    = SW'(cs_ff);
               psl_in   = 1'b0;
               ret_in   = S_SWK2;
               state_in = S_PSH1;
            end else begin
               prev_in  = cs_ff;
               cs_in    = link_q;
               guard_in = guard_ff + PW'(1);
               state_in = S_SWK0;
            end
         end
         S_SWK2: begin
            cs_in    = nxt_ff;
            guard_in = guard_ff + PW'(1);
            state_in = S_SWK0;
         end
         S_DSP0: begin
            if (rhead_ff == NONE) begin
               state_in = S_OUT;
            end else begin
               rd_addr  = SW'(rhead_ff);
               state_in = S_DSP1;
            end
         end
         S_DSP1: begin
            if (link_q == NONE) begin
               rhead_in = NONE;
               rtail_in = NONE;
            end else begin
               rhead_in = link_q;
            end
            lk_we    = 1'b1;
            lk_wa    = SW'(rhead_ff);
            lk_wd    = NONE;
            st_we    = 1'b1;
            st_wa    = SW'(rhead_ff);
            st_wd    = SS_RUNNING;
            cur_in   = SW'(rhead_ff);
            state_in = S_OUT;
         end
         S_SLPCHK: begin
            if (amt_ff == '0 || st_q != SS_RUNNING) begin
               status_in = STAT_NOOP;
               state_in  = S_OUT;
            end else begin
               dreq.start = 1'b1;
               state_in   = S_SLPDIV;
            end
         end
         S_SLPDIV: begin
            if (drsp.done) begin
               wk_we    = 1'b1;
               st_we    = 1'b1;
               st_wa    = cur_ff;
               st_wd    = SS_SLEEP;
               ps_in    = cur_ff;
               psl_in   = 1'b1;
               ret_in   = S_SCH0;
               state_in = S_PSH1;
            end
         end
         S_KCHK: begin
            prev_in  = NONE;
            guard_in = '0;
            if (tbad_ff || st_q == SS_FREE) begin
               status_in = STAT_BAD_SLOT;
               state_in  = S_OUT;
            end else if (st_q == SS_SLEEP) begin
               rl_in    = 1'b1;
               cs_in    = shead_ff;
               state_in = S_RM0;
            end else if (st_q == SS_READY) begin
               rl_in    = 1'b0;
               cs_in    = rhead_ff;
               state_in = S_RM0;
            end else begin
               state_in = S_KFREE;
            end
         end
         // unlink walk
         S_RM0: begin
            if (cs_ff == NONE || guard_ff == PW'(MAX_THREADS)) begin
               state_in = S_KFREE;
            end else begin
               rd_addr  = SW'(cs_ff);
               state_in = S_RM1;
            end
         end
         S_RM1: begin
            if (cs_ff == PW'(tgt_ff)) begin
               if (prev_ff == NONE) begin
                  if (rl_ff) shead_in = link_q;
                  else       rhead_in = link_q;
               end else begin
                  lk_we = 1'b1;
                  lk_wa = SW'(prev_ff);
                  lk_wd = link_q;
               end
               if (rl_ff && stail_ff == PW'(tgt_ff))  stail_in = prev_ff;
               if (!rl_ff && rtail_ff == PW'(tgt_ff)) rtail_in = prev_ff;
               state_in = S_KFREE;
            end else begin
               prev_in  = cs_ff;
               cs_in    = link_q;
               guard_in = guard_ff + PW'(1);
               state_in = S_RM0;
            end
         end
         S_KFREE: begin
            st_we = 1'b1;
            st_wa = tgt_ff;
            st_wd = SS_FREE;
            if (tgt_ff == cur_ff) state_in = S_SCH0;
            else                  state_in = S_OUT;
         end
         // list append
         S_PSH1: begin
            lk_we = 1'b1;
            lk_wa = ps_ff;
            lk_wd = NONE;
            if (psl_ff) begin
               if (shead_ff == NONE || stail_ff == NONE) begin
                  shead_in = PW'(ps_ff);
                  stail_in = PW'(ps_ff);
                  state_in = ret_ff;
               end else begin
                  state_in = S_PSH2;
               end
            end else begin
               if (rhead_ff == NONE || rtail_ff == NONE) begin
                  rhead_in = PW'(ps_ff);
                  rtail_in = PW'(ps_ff);
                  state_in = ret_ff;
               end else begin
                  state_in = S_PSH2;
               end
            end
         end
         S_PSH2: begin
            lk_we = 1'b1;
            lk_wd = PW'(ps_ff);
            if (psl_ff) begin
               lk_wa    = SW'(stail_ff);
               stail_in = PW'(ps_ff);
            end else begin
               lk_wa    = SW'(rtail_ff);
               rtail_in = PW'(ps_ff);
            end
            state_in = ret_ff;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;  ret_ff   <= S_IDLE;
         rhead_ff  <= NONE;    rtail_ff <= NONE;
         shead_ff  <= NONE;    stail_ff <= NONE;
         cur_ff    <= '0;      old_ff   <= '0;
         idc_ff    <= ID_W'(1);
         cmd_ff    <= '0;      now_ff   <= '0;    amt_ff <= '0;
         tgt_ff    <= '0;      sc_ff    <= '0;    ps_ff  <= '0;
         tbad_ff   <= 1'b0;    psl_ff   <= 1'b0;  rl_ff  <= 1'b0;
         cs_ff     <= NONE;    prev_ff  <= NONE;  nxt_ff <= NONE;
         guard_ff  <= '0;      woken_ff <= '0;
         status_ff <= STAT_OK; nslot_ff <= '0;    nid_ff <= '0;
         for (int i = 0; i < MAX_THREADS; i++) st_vld_ff[i] <= 1'b0;
      end else begin
         state_ff  <= state_in;  ret_ff   <= ret_in;
         rhead_ff  <= rhead_in;  rtail_ff <= rtail_in;
         shead_ff  <= shead_in;  stail_ff <= stail_in;
         cur_ff    <= cur_in;    old_ff   <= old_in;
         idc_ff    <= idc_in;
         cmd_ff    <= cmd_in;    now_ff   <= now_in;   amt_ff <= amt_in;
         tgt_ff    <= tgt_in;    sc_ff    <= sc_in;    ps_ff  <= ps_in;
         tbad_ff   <= tbad_in;   psl_ff   <= psl_in;   rl_ff  <= rl_in;
         cs_ff     <= cs_in;     prev_ff  <= prev_in;  nxt_ff <= nxt_in;
         guard_ff  <= guard_in;  woken_ff <= woken_in;
         status_ff <= status_in; nslot_ff <= nslot_in; nid_ff <= nid_in;
         if (st_we) st_vld_ff[st_wa] <= 1'b1;
      end
   end

   // slot state memory, unwritten entries read as their reset state
   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_wa] <= st_wd;
      if (st_vld_ff[rd_addr])    st_q <= st_mem[rd_addr];
      else if (rd_addr == '0)    st_q <= SS_RUNNING;
      else                       st_q <= SS_FREE;
   end

   always_ff @(posedge clock) begin
      if (lk_we) link_mem[lk_wa] <= lk_wd;
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wk_we) wake_mem[cur_ff] <= wt;
      wake_q <= wake_mem[rd_addr];
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = (state_ff == S_OUT);
   assign rsp.status       = status_ff;
   assign rsp.running_slot = SLOTF_W'(cur_ff);
   assign rsp.switched     = (cur_ff != old_ff);
   assign rsp.new_slot     = nslot_ff;
   assign rsp.new_id       = nid_ff;
   assign rsp.woken_count  = WOKEN_W'(woken_ff);

endmodule

FILE: hdl/fifo_thread_scheduler_with_sleep_list.sv
// Thread scheduler over MAX_THREADS slots with a FIFO ready list and a sleep list, both
// linked through one next-pointer memory. Commands are taken one at a time; req ready is
// low until the result transfer completes. All list and slot work runs on a sequencer:
// create scans for the lowest free slot; a schedule walks the sleep list, waking each
// sleeper whose wake time has passed, then dispatches the ready head; kill walks the
// owning list of a ready or sleeping target and schedules only if the target is running.
// Sleep in seconds runs the multiply; sleep in milliseconds also runs the divide by 1000
// done as four 13-bit reciprocal steps. The tick rate register is written through the
// csr channel, which is always ready.
module fifo_thread_scheduler_with_sleep_list #(
   parameter int MAX_THREADS = fts_pkg::DEF_MAX_THREADS
) (
   input logic       clock,
   input logic       reset,
   fts_req_if.sink   req_chan,
   fts_rsp_if.source rsp_chan,
   fts_csr_if.sink   csr_chan
);
   import fts_pkg::*;

   logic [RATE_W-1:0] tick_rate_ff;
   div_req_type       dreq;
   div_rsp_type       drsp;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else if (csr_chan.valid) begin
         tick_rate_ff <= csr_chan.data;
      end
   end

   fts_core #(.MAX_THREADS(MAX_THREADS)) u_core (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   fts_div u_div (
      .clock (clock),
      .reset (reset),
      .rate  (tick_rate_ff),
      .dreq  (dreq),
      .drsp  (drsp)
   );

endmodule

FILE: hdl/fts_chk.sv
module fts_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fts_pkg::STATUS_W-1:0] rsp_status,
   input logic [fts_pkg::ID_W-1:0]     rsp_new_id
);
   import fts_pkg::*;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after an input transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before transfer");

   a_no_id_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_new_id == '0))
      else $error("id reported for a failed command");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind fifo_thread_scheduler_with_sleep_list fts_chk u_fts_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_new_id (rsp_chan.new_id)
);

FILE: tb/fifo_thread_scheduler_with_sleep_list_test.sv
`timescale 1ns / 100ps

module fifo_thread_scheduler_with_sleep_list_test;
   import fts_pkg::*;

   localparam int NSLOT = DEF_MAX_THREADS;
   localparam logic [4:0] NIL = 5'(NSLOT);
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOTF_W-1:0]  running_slot;
      logic                switched;
      logic [SLOTF_W-1:0]  new_slot;
      logic [ID_W-1:0]     new_id;
      logic [WOKEN_W-1:0]  woken_count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fts_req_if req_chan ();
   fts_rsp_if rsp_chan ();
   fts_csr_if csr_chan ();

   fifo_thread_scheduler_with_sleep_list i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler state mirror
   slot_state_type   slot_st [NSLOT];
   logic [63:0]      wake_at [NSLOT];
   logic [4:0]       next_of [NSLOT];
   logic [4:0]       rdy_head, rdy_tail, slp_head, slp_tail;
   logic [4:0]       cur_slot;
   logic [ID_W-1:0]  next_id;
   logic [RATE_W-1:0] tick_rate;

   outcome_type expected_outcomes[$];
   int   failures = 0;
   int   idle_cycles = 0;
   bit   hold_rsp = 1'b0;
   int   created_cnt = 0;

   function automatic void list_append(ref logic [4:0] head, ref logic [4:0] tail,
                                       input logic [4:0] s);
      next_of[s] = NIL;
      if (head >= NIL || tail >= NIL) begin
         head = s;
         tail = s;
      end else begin
         next_of[tail] = s;
         tail = s;
      end
   endfunction

   function automatic void list_unlink(ref logic [4:0] head, ref logic [4:0] tail,
                                       input logic [4:0] s);
      logic [4:0] prv, cur, nxt;
      int n;
      prv = NIL;
      cur = head;
      n = 0;
      while (cur < NIL && n < NSLOT) begin
         nxt = next_of[cur];
         if (cur == s) begin
            if (prv >= NIL) head = nxt;
            else next_of[prv] = nxt;
            if (tail == s) tail = prv;
            next_of[s] = NIL;
            return;
         end
         prv = cur;
         cur = nxt;
         n++;
      end
   endfunction

   function automatic int run_dispatch(input logic [63:0] now, output logic sw);
      int woke, n;
      logic [4:0] prv, cur, nxt, old, h;
      woke = 0;
      n = 0;
      old = cur_slot;
      prv = NIL;
      if (cur_slot < NIL && slot_st[cur_slot] == SS_RUNNING) begin
         slot_st[cur_slot] = SS_READY;
         list_append(rdy_head, rdy_tail, cur_slot);
      end
      cur = slp_head;
      while (cur < NIL && n < NSLOT) begin
         nxt = next_of[cur];
         if (now >= wake_at[cur]) begin
            if (prv >= NIL) slp_head = nxt;
            else next_of[prv] = nxt;
            if (slp_tail == cur) slp_tail = prv;
            slot_st[cur] = SS_READY;
            list_append(rdy_head, rdy_tail, cur);
            woke++;
         end else begin
            prv = cur;
         end
         cur = nxt;
         n++;
      end
      if (rdy_head < NIL) begin
         h = rdy_head;
         rdy_head = next_of[h];
         if (rdy_head >= NIL) begin
            rdy_head = NIL;
            rdy_tail = NIL;
         end
         next_of[h] = NIL;
         cur_slot = h;
         slot_st[h] = SS_RUNNING;
      end
      sw = (cur_slot != old);
      return woke;
   endfunction

   function automatic void scheduler_reset();
      foreach (slot_st[i]) begin
         slot_st[i] = SS_FREE;
         wake_at[i] = '0;
         next_of[i] = '0;
      end
      slot_st[0] = SS_RUNNING;
      rdy_head = NIL;
      rdy_tail = NIL;
      slp_head = NIL;
      slp_tail = NIL;
      cur_slot = '0;
      next_id = 1;
      tick_rate = TICK_RATE_RESET;
   endfunction

   function automatic outcome_type predict_outcome(input logic [CMD_W-1:0] cmd,
         input logic [63:0] now, input logic [31:0] amount, input logic [3:0] target);
      outcome_type o;
      logic sw;
      logic [63:0] delay, wt;
      logic [4:0] t;
      int woke;
      o = '0;
      o.status = STAT_NOOP;
      sw = 1'b0;
      woke = 0;
      case (cmd)
         CMD_CREATE: begin
            o.status = STAT_FULL;
            for (int s = 0; s < NSLOT; s++) begin
               if (slot_st[s] == SS_FREE) begin
                  o.new_slot = SLOTF_W'(s);
                  o.new_id = next_id;
                  next_id = next_id + 1;
                  slot_st[s] = SS_READY;
                  list_append(rdy_head, rdy_tail, 5'(s));
                  o.status = STAT_OK;
                  break;
               end
            end
         end
         CMD_SCHED: begin
            woke = run_dispatch(now, sw);
            o.status = STAT_OK;
         end
         CMD_SLEEP_MS, CMD_SLEEP_S: begin
            if (amount != 0 && cur_slot < NIL && slot_st[cur_slot] == SS_RUNNING) begin
               delay = 64'(amount) * 64'(tick_rate);
               if (cmd == CMD_SLEEP_MS) delay = delay / MS_PER_S;
               wt = now + delay;
               if (wt < now) wt = '1;
               wake_at[cur_slot] = wt;
               slot_st[cur_slot] = SS_SLEEP;
               list_append(slp_head, slp_tail, cur_slot);
               woke = run_dispatch(now, sw);
               o.status = STAT_OK;
            end
         end
         CMD_KILL, CMD_EXIT: begin
            t = (cmd == CMD_KILL) ? 5'(target) : cur_slot;
            if (t >= NIL || slot_st[t] == SS_FREE) begin
               o.status = STAT_BAD_SLOT;
            end else begin
               list_unlink(slp_head, slp_tail, t);
               list_unlink(rdy_head, rdy_tail, t);
               if (rdy_head >= NIL || rdy_tail >= NIL) begin
                  rdy_head = NIL;
                  rdy_tail = NIL;
               end
               if (slp_head >= NIL || slp_tail >= NIL) begin
                  slp_head = NIL;
                  slp_tail = NIL;
               end
               slot_st[t] = SS_FREE;
               if (t == cur_slot) woke = run_dispatch(now, sw);
               o.status = STAT_OK;
            end
         end
         default: ;
      endcase
      o.running_slot = cur_slot[3:0];
      o.switched = sw;
      o.woken_count = WOKEN_W'(woke);
      return o;
   endfunction

   task automatic idle_gap(input int long_pct);
      int n;
      if ($urandom_range(99) < long_pct) n = $urandom_range(40, 8);
      else if ($urandom_range(1)) n = $urandom_range(2);
      else n = 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [63:0] now,
                               input logic [31:0] amount, input logic [3:0] target,
                               input bit gaps = 1'b1);
      if (gaps) idle_gap(4);
      @(posedge clock);
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.now_ticks <= now;
      req_chan.amount <= amount;
      req_chan.target_slot <= target;
      do @(posedge clock); while (!req_chan.ready);
      expected_outcomes.push_back(predict_outcome(cmd, now, amount, target));
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain_outcomes();
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
      drain_outcomes();
      csr_chan.valid <= 1'b1;
      csr_chan.data <= rate;
      do @(posedge clock); while (!csr_chan.ready);
      tick_rate = rate;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // random tick value: mostly small and near, sometimes extreme
   function automatic logic [63:0] rand_now();
      case ($urandom_range(9))
         0: return {$urandom, $urandom};
         1: return '1 - 64'($urandom_range(3));
         default: return 64'($urandom_range(3000));
      endcase
   endfunction

   function automatic logic [31:0] rand_amount();
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         2: return 0;
         default: return 32'($urandom_range(2000, 1));
      endcase
   endfunction

   task automatic test_directed();
      send_command(CMD_SCHED, 64'd0, 32'd0, 4'd0);
      send_command(CMD_EXIT, 64'd0, 32'd0, 4'd0);
      send_command(CMD_EXIT, 64'd0, 32'd0, 4'd0);
      send_command(CMD_KILL, 64'd0, 32'd0, 4'd15);
      send_command(CMD_SLEEP_MS, 64'd0, 32'd5, 4'd0);
      for (int i = 0; i < 17; i++) send_command(CMD_CREATE, 64'd0, 32'd0, 4'd0);
      send_command(CMD_SLEEP_S, 64'd0, 32'd0, 4'd0);
      send_command(CMD_SLEEP_MS, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF, 4'd0);
      send_command(CMD_SLEEP_S, 64'd10, 32'd1, 4'd0);
      send_command(CMD_SCHED, 64'd5000, 32'd0, 4'd0);
      send_command(CMD_KILL, 64'd0, 32'd0, 4'd1);
      send_command(3'd6, 64'd0, 32'd0, 4'd0);
      send_command(3'd7, '1, '1, 4'd15);
   endtask

   task automatic random_phase(input int count);
      logic [CMD_W-1:0] cmd;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 20) cmd = CMD_CREATE;
         else if (pick < 45) cmd = CMD_SCHED;
         else if (pick < 60) cmd = CMD_SLEEP_MS;
         else if (pick < 72) cmd = CMD_SLEEP_S;
         else if (pick < 86) cmd = CMD_KILL;
         else if (pick < 97) cmd = CMD_EXIT;
         else cmd = 3'($urandom_range(7, 6));
         send_command(cmd, rand_now(), rand_amount(), 4'($urandom_range(15)));
      end
   endtask

   task automatic test_rates();
      write_tick_rate(RATE_W'(1));
      random_phase(150);
      write_tick_rate(RATE_W'(1000000));
      random_phase(150);
      write_tick_rate(RATE_W'($urandom_range(999999, 2)));
      random_phase(150);
      write_tick_rate(RATE_W'(1000));
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 10; i++)
            send_command(CMD_CREATE, 64'd0, 32'd0, 4'd0, 1'b0);
      join
   endtask

   task automatic test_random();
      random_phase(250);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !hold_rsp && ($urandom_range(9) < 7 ||
                           ($urandom_range(49) == 0 ? 1'b0 : 1'b1));
      end
   end

   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status = rsp_chan.status;
         got.running_slot = rsp_chan.running_slot;
         got.switched = rsp_chan.switched;
         got.new_slot = rsp_chan.new_slot;
         got.new_id = rsp_chan.new_id;
         got.woken_count = rsp_chan.woken_count;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected transfer %p", $time, got);
            failures++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("fifo_thread_scheduler_with_sleep_list_test: FAIL");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_CREATE;
      req_chan.now_ticks = '0;
      req_chan.amount = '0;
      req_chan.target_slot = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      scheduler_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_rates();
      test_random();
      drain_outcomes();
      if (failures == 0)
         $display("fifo_thread_scheduler_with_sleep_list_test: PASS");
      else
         $display("fifo_thread_scheduler_with_sleep_list_test: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/fts_pkg.sv
hdl/fts_ifs.sv
hdl/fts_div.sv
hdl/fts_core.sv
hdl/fifo_thread_scheduler_with_sleep_list.sv
hdl/fts_chk.sv
tb/fifo_thread_scheduler_with_sleep_list_test.sv
